>>> design/sibd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sibd_pkg: shared types for the density sorter
// Controller states and the command/status structs between control and data.
// ----------------------------------------------------------------------------
package sibd_pkg;

  localparam int unsigned FieldBits = 32;
  localparam int unsigned TagBits   = 6;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RD_KEY,
    ST_RD_CMP,
    ST_CMP,
    ST_PLACE,
    ST_EMIT_RD,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic store_in;    // write the input item at the fill index
    logic key_load;    // latch key from read data
    logic rd_prev;     // read entry at scan index - 1
    logic rd_key;      // read entry at key index
    logic cmp_start;   // start a multiply/compare
    logic shift_down;  // move the compared entry up one slot
    logic place_key;   // write the key at the scan index
    logic rd_emit;     // read entry at emit index
    logic emit_load;   // latch output register
  } cmd_t;

  typedef struct packed {
    logic cmp_done;
    logic denser;      // compared entry strictly denser than key
  } status_t;

endpackage : sibd_pkg
`default_nettype wire

>>> design/sibd_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sibd_datapath: item store, key register and cross-multiply comparator
// One memory port pair: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sibd_datapath #(
  parameter int unsigned MaxItems  = 64,
  parameter int unsigned ValueBits = 32,
  parameter int unsigned IdxBits   = 6
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  sibd_pkg::cmd_t             cmd_i,
  output sibd_pkg::status_t          status_o,
  input  wire [IdxBits-1:0]          fill_idx_i,
  input  wire [IdxBits-1:0]          key_idx_i,
  input  wire [IdxBits-1:0]          scan_idx_i,
  input  wire [IdxBits-1:0]          emit_idx_i,
  input  wire [ValueBits-1:0]        mass_i,
  input  wire [ValueBits-1:0]        volume_i,
  input  wire [sibd_pkg::TagBits-1:0] tag_i,
  output logic [ValueBits-1:0]       mass_o,
  output logic [ValueBits-1:0]       volume_o,
  output logic [sibd_pkg::TagBits-1:0] tag_o
);
  import sibd_pkg::*;

  localparam int unsigned EntryBits = 2 * ValueBits + TagBits;
  localparam int unsigned ProdBits  = 2 * ValueBits;

  logic [EntryBits-1:0] mem_q [MaxItems];
  logic [EntryBits-1:0] rd_q;
  logic [EntryBits-1:0] key_q;
  logic                 wr_en;
  logic [IdxBits-1:0]   wr_idx;
  logic [EntryBits-1:0] wr_data;
  logic [IdxBits-1:0]   rd_idx;
  logic [ValueBits-1:0] vol_in;
  logic [ProdBits-1:0]  lhs_q, rhs_q;
  logic                 cmp_q;

  assign vol_in = (volume_i == '0) ? ValueBits'(1) : volume_i;

  always_comb begin
    wr_en   = cmd_i.store_in | cmd_i.shift_down | cmd_i.place_key;
    wr_idx  = fill_idx_i;
    wr_data = {mass_i, vol_in, tag_i};
    if (cmd_i.shift_down) begin
      wr_idx  = scan_idx_i;
      wr_data = rd_q;
    end else if (cmd_i.place_key) begin
      wr_idx  = scan_idx_i;
      wr_data = key_q;
    end
  end

  always_comb begin
    rd_idx = emit_idx_i;
    if (cmd_i.rd_key) begin
      rd_idx = key_idx_i;
    end else if (cmd_i.rd_prev) begin
      rd_idx = scan_idx_i - IdxBits'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_idx] <= wr_data;
    end
    rd_q <= mem_q[rd_idx];
    if (cmd_i.key_load) begin
      key_q <= rd_q;
    end
    if (cmd_i.cmp_start) begin
      // prev.mass * key.vol vs key.mass * prev.vol
      lhs_q <= ProdBits'(rd_q[EntryBits-1 -: ValueBits]) *
               ProdBits'(key_q[TagBits +: ValueBits]);
      rhs_q <= ProdBits'(key_q[EntryBits-1 -: ValueBits]) *
               ProdBits'(rd_q[TagBits +: ValueBits]);
    end
    if (cmd_i.emit_load) begin
      {mass_o, volume_o, tag_o} <= rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_q <= 1'b0;
    end else begin
      cmp_q <= cmd_i.cmp_start;
    end
  end

  assign status_o.cmp_done = cmp_q;
  assign status_o.denser   = lhs_q > rhs_q;

endmodule : sibd_datapath
`default_nettype wire

>>> design/sibd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sibd_ctrl: load, insertion-sort and emit sequencer
// Walks each new key down the stored run, then streams the sorted store out.
// ----------------------------------------------------------------------------
module sibd_ctrl #(
  parameter int unsigned MaxItems = 64,
  parameter int unsigned IdxBits  = 6
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wire                 last_in_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output logic                last_out_o,
  output sibd_pkg::cmd_t      cmd_o,
  input  sibd_pkg::status_t   status_i,
  output logic [IdxBits-1:0]  fill_idx_o,
  output logic [IdxBits-1:0]  key_idx_o,
  output logic [IdxBits-1:0]  scan_idx_o,
  output logic [IdxBits-1:0]  emit_idx_o
);
  import sibd_pkg::*;

  localparam int unsigned CntBits = IdxBits + 1;

  state_e             state_q, state_d;
  logic [CntBits-1:0] count_q, count_d;
  logic [CntBits-1:0] key_q, key_d;
  logic [IdxBits-1:0] scan_q, scan_d;
  logic [CntBits-1:0] emit_q, emit_d;
  logic               ovalid_q, ovalid_d;
  logic               olast_q, olast_d;
  logic               in_acc, out_acc, full;

  assign full       = count_q == CntBits'(MaxItems);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = ovalid_q && !out_stall_i;
  assign in_stall_o = state_q != ST_LOAD;
  assign out_valid_o = ovalid_q;
  assign last_out_o  = olast_q;
  assign fill_idx_o  = count_q[IdxBits-1:0];
  assign key_idx_o   = key_q[IdxBits-1:0];
  assign scan_idx_o  = scan_q;
  assign emit_idx_o  = emit_q[IdxBits-1:0];

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    key_d    = key_q;
    scan_d   = scan_q;
    emit_d   = emit_q;
    ovalid_d = ovalid_q && !out_acc;
    olast_d  = olast_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (!full) begin
            count_d = count_q + CntBits'(1);
          end
          if (last_in_i) begin
            key_d   = CntBits'(1);
            state_d = ST_RD_KEY;
          end
        end
      end
      ST_RD_KEY: begin
        if (key_q >= count_q) begin
          emit_d  = '0;
          state_d = ST_EMIT_RD;
        end else begin
          scan_d  = key_q[IdxBits-1:0];
          state_d = ST_RD_CMP;
        end
      end
      ST_RD_CMP: state_d = ST_CMP;
      ST_CMP: begin
        if (status_i.cmp_done) begin
          if (status_i.denser) begin
            scan_d = scan_q - IdxBits'(1);
            state_d = (scan_q == IdxBits'(1)) ? ST_PLACE : ST_RD_CMP;
          end else begin
            key_d   = key_q + CntBits'(1);
            state_d = ST_RD_KEY;
          end
        end
      end
      ST_PLACE: begin
        key_d   = key_q + CntBits'(1);
        state_d = ST_RD_KEY;
      end
      ST_EMIT_RD: begin
        if (!ovalid_q || out_acc) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        ovalid_d = 1'b1;
        olast_d  = emit_q == count_q - CntBits'(1);
        emit_d   = emit_q + CntBits'(1);
        if (olast_d) begin
          count_d = '0;
          state_d = ST_LOAD;
        end else begin
          state_d = ST_EMIT_RD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // Command decode; key is read in ST_RD_KEY, latched in ST_RD_CMP
  // together with the first neighbor read issued there.
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_LOAD:    cmd_o.store_in = in_acc && !full;
      ST_RD_KEY: begin
        cmd_o.rd_key = 1'b1;
        if (key_q > CntBits'(1) && key_q < count_q) begin
          cmd_o.place_key = 1'b0;
        end
      end
      ST_RD_CMP: begin
        cmd_o.rd_prev = 1'b1;
        cmd_o.key_load = scan_q == key_q[IdxBits-1:0];
      end
      ST_CMP: begin
        cmd_o.rd_prev   = 1'b1;
        cmd_o.cmp_start = !status_i.cmp_done;
        if (status_i.cmp_done) begin
          if (status_i.denser) begin
            cmd_o.shift_down = 1'b1;
          end else begin
            cmd_o.place_key = 1'b1;
          end
        end
      end
      ST_PLACE:   cmd_o.place_key = 1'b1;
      ST_EMIT_RD: cmd_o.rd_emit = 1'b1;
      ST_EMIT:    cmd_o.emit_load = 1'b1;
      default:    cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      count_q  <= '0;
      key_q    <= '0;
      scan_q   <= '0;
      emit_q   <= '0;
      ovalid_q <= 1'b0;
      olast_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      key_q    <= key_d;
      scan_q   <= scan_d;
      emit_q   <= emit_d;
      ovalid_q <= ovalid_d;
      olast_q  <= olast_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntBits'(MaxItems)) else $error("fill count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && out_stall_i |=> ovalid_q) else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> !ovalid_q)
    else $error("output register overwritten");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CMP |-> scan_q != '0) else $error("scan at head");

endmodule : sibd_ctrl
`default_nettype wire

>>> design/sort_items_by_density.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sort_items_by_density: stable sort of a loaded set by mass/volume
// Load channel takes mass, volume, tag and last_in, one item per cycle while
// stall_o is low. The item with last_in set closes the set; items beyond
// MaxItems are dropped, a zero volume loads as one. Stall then rises while an
// insertion sort runs in the store: each key walks down the sorted run one
// entry at a time (read, multiply, compare and shift). Results then leave in
// ascending density, ties in load order, from the single store read port,
// the next one read only once the output register is free or taken, and
// last_out on the final one. A high stall_i holds the output register and
// the emit sequencer. Reset empties the set and drops any pending result;
// stored data is not cleared.
// Throughput: one set at a time, no overlap between sort and load.
// ----------------------------------------------------------------------------
module sort_items_by_density #(
  parameter int unsigned MAX_ITEMS  = 64,
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           valid_i,
  output logic                          stall_o,
  input  wire  [sibd_pkg::FieldBits-1:0] mass_i,
  input  wire  [sibd_pkg::FieldBits-1:0] volume_i,
  input  wire  [sibd_pkg::TagBits-1:0]  tag_i,
  input  wire                           last_in_i,
  output logic                          valid_o,
  input  wire                           stall_i,
  output logic [sibd_pkg::FieldBits-1:0] out_mass_o,
  output logic [sibd_pkg::FieldBits-1:0] out_volume_o,
  output logic [sibd_pkg::TagBits-1:0]  out_tag_o,
  output logic                          last_out_o
);
  import sibd_pkg::*;

  localparam int unsigned IdxBits = $clog2(MAX_ITEMS);

  cmd_t               cmd;
  status_t            status;
  logic [IdxBits-1:0] fill_idx, key_idx, scan_idx, emit_idx;
  logic [VALUE_BITS-1:0] mass_o, vol_o;

  sibd_ctrl #(.MaxItems(MAX_ITEMS), .IdxBits(IdxBits)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(valid_i), .in_stall_o(stall_o), .last_in_i,
    .out_valid_o(valid_o), .out_stall_i(stall_i), .last_out_o,
    .cmd_o(cmd), .status_i(status),
    .fill_idx_o(fill_idx), .key_idx_o(key_idx),
    .scan_idx_o(scan_idx), .emit_idx_o(emit_idx)
  );

  sibd_datapath #(.MaxItems(MAX_ITEMS), .ValueBits(VALUE_BITS), .IdxBits(IdxBits)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status),
    .fill_idx_i(fill_idx), .key_idx_i(key_idx),
    .scan_idx_i(scan_idx), .emit_idx_i(emit_idx),
    .mass_i(mass_i[VALUE_BITS-1:0]), .volume_i(volume_i[VALUE_BITS-1:0]),
    .tag_i, .mass_o, .volume_o(vol_o), .tag_o(out_tag_o)
  );

  assign out_mass_o   = FieldBits'(mass_o);
  assign out_volume_o = FieldBits'(vol_o);

endmodule : sort_items_by_density
`default_nettype wire
